// File: hdl/thread_delay_timer_bank_unit_defines.svh
// ----------------------------------------------------------------------------
// Thread delay timer bank - assertion macros
// Concurrent check macros used by the top-level RTL file; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef THREAD_DELAY_TIMER_BANK_UNIT_DEFINES_SVH
`define THREAD_DELAY_TIMER_BANK_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication check
`define TDTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check
`define TDTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TDTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TDTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hdl/tdtb_pkg.sv
// ----------------------------------------------------------------------------
// Thread delay timer bank - package
// Field widths, request codes and the structs between sequencer and bank.
// ----------------------------------------------------------------------------
package tdtb_pkg;

  localparam int REQ_W  = 3;
  localparam int THR_W  = 3;
  localparam int CNT_W  = 16;
  localparam int MASK_W = 8;
  localparam int TICK_W = 32;

  // Disabled mask after reset: only thread zero runs
  localparam logic [MASK_W-1:0] DIS_RST = 8'hFE;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 3'd0,
    REQ_DELAY   = 3'd1,
    REQ_SUSPEND = 3'd2,
    REQ_RESUME  = 3'd3,
    REQ_DISABLE = 3'd4,
    REQ_ENABLE  = 3'd5
  } req_type_t;

  // Sequencer to counter bank
  typedef struct packed {
    logic             we;
    logic [THR_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic             re;
    logic [THR_W-1:0] raddr;
  } cnt_ctl_t;

  // Counter bank to sequencer
  typedef struct packed {
    logic             nz;
    logic             expire;
    logic [CNT_W-1:0] dec;
  } cnt_sts_t;

endpackage

// File: hdl/tdtb_req_if.sv
// ----------------------------------------------------------------------------
// Thread delay timer bank - request channel
// Valid/ready channel carrying one kernel request item.
// ----------------------------------------------------------------------------
interface tdtb_req_if;
  logic                          valid;
  logic                          ready;
  logic [tdtb_pkg::REQ_W-1:0]    req_type;
  logic [tdtb_pkg::THR_W-1:0]    thread_sel;
  logic [tdtb_pkg::CNT_W-1:0]    delay_ticks;

  modport source (output valid, req_type, thread_sel, delay_ticks, input ready);
  modport sink   (input valid, req_type, thread_sel, delay_ticks, output ready);
endinterface

// File: hdl/tdtb_res_if.sv
// ----------------------------------------------------------------------------
// Thread delay timer bank - result channel
// Valid/ready channel carrying the thread masks and tick total.
// ----------------------------------------------------------------------------
interface tdtb_res_if;
  logic                          valid;
  logic                          ready;
  logic [tdtb_pkg::MASK_W-1:0]   disabled_mask;
  logic [tdtb_pkg::MASK_W-1:0]   suspended_mask;
  logic [tdtb_pkg::MASK_W-1:0]   ready_mask;
  logic [tdtb_pkg::TICK_W-1:0]   tick_total;

  modport source (output valid, disabled_mask, suspended_mask, ready_mask, tick_total,
                  input ready);
  modport sink   (input valid, disabled_mask, suspended_mask, ready_mask, tick_total,
                  output ready);
endinterface

// File: hdl/tdtb_ctr_bank.sv
// ----------------------------------------------------------------------------
// Thread delay timer bank - counter bank
// Delay counter memory with one write and one registered read port, and the
// shared decrement unit that the tick scan walks over every thread.
// ----------------------------------------------------------------------------
module tdtb_ctr_bank #(
  parameter int THREAD_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tdtb_pkg::cnt_ctl_t  ctl,
  output tdtb_pkg::cnt_sts_t  sts
);
  import tdtb_pkg::*;

  localparam int IDX_W = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;

  logic [CNT_W-1:0]        mem [THREAD_COUNT];
  logic [THREAD_COUNT-1:0] vld_r;
  logic [CNT_W-1:0]        rdata_r;
  logic                    rvld_r;
  logic [CNT_W-1:0]        cnt;

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr[IDX_W-1:0]] <= ctl.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem[ctl.raddr[IDX_W-1:0]];
    end
  end

  // Entry valid bits: an unwritten counter reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (ctl.we) begin
        vld_r[ctl.waddr[IDX_W-1:0]] <= 1'b1;
      end
      if (ctl.re) begin
        rvld_r <= vld_r[ctl.raddr[IDX_W-1:0]];
      end
    end
  end

  // Shared decrement and zero detect
  assign cnt        = rvld_r ? rdata_r : '0;
  assign sts.nz     = |cnt;
  assign sts.expire = (cnt == CNT_W'(1));
  assign sts.dec    = cnt - CNT_W'(1);

endmodule

// File: hdl/thread_delay_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// Thread delay timer bank - top level
// Per-thread delay counters, disabled and suspended masks and a tick count,
// with a sequencer that walks the counters through one shared decrementer.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields                                            Handshake
//  in_ch     in   req_type, thread_sel, delay_ticks                 valid/ready
//  out_ch    out  disabled_mask, suspended_mask, ready_mask,        valid/ready
//                 tick_total
//
//  A non-tick request is applied at acceptance; its result is valid the next
//  cycle. A tick visits each thread with a read state and then an update
//  state, through the counter memory's single read port and the shared
//  decrementer, then a finish state. in_ch.ready is low during a tick scan
//  and while an unread result holds the output register. Reset: only thread
//  zero enabled, all counters and the tick count zero; no clearing pass.
// ----------------------------------------------------------------------------
`include "thread_delay_timer_bank_unit_defines.svh"

module thread_delay_timer_bank_unit #(
  parameter int THREAD_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  tdtb_req_if.sink   in_ch,
  tdtb_res_if.source out_ch
);
  import tdtb_pkg::*;

  localparam int               IDX_W    = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(THREAD_COUNT - 1);
  localparam logic [MASK_W-1:0] ALL_M   = MASK_W'((9'd1 << THREAD_COUNT) - 9'd1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t             st_r, st_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [MASK_W-1:0]  dis_r, dis_nxt;
  logic [MASK_W-1:0]  sus_r, sus_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]  out_dis_r, out_sus_r, out_rdy_r;
  logic [TICK_W-1:0]  out_tick_r;

  logic               in_acc;
  logic               is_tick;
  logic               sel_ok;
  logic [MASK_W-1:0]  sel_m;
  logic               load;
  cnt_ctl_t           ctl;
  cnt_sts_t           sts;

  tdtb_ctr_bank #(
    .THREAD_COUNT (THREAD_COUNT)
  ) u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sts   (sts)
  );

  // Accept only when idle and the output register is free or draining
  assign in_ch.ready = (st_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_tick     = (in_ch.req_type == REQ_TICK);
  assign sel_ok      = ({29'd0, in_ch.thread_sel} < 32'(THREAD_COUNT));
  assign sel_m       = sel_ok ? (MASK_W'(1) << in_ch.thread_sel) : '0;

  // Sequencer and mask updates
  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    dis_nxt  = dis_r;
    sus_nxt  = sus_r;
    tick_nxt = tick_r;
    load     = 1'b0;
    ctl      = '0;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_tick) begin
            tick_nxt = tick_r + TICK_W'(1);
            idx_nxt  = '0;
            st_nxt   = ST_RD;
          end else begin
            load = 1'b1;
            case (in_ch.req_type)
              REQ_DELAY: begin
                dis_nxt   = dis_r | sel_m;
                ctl.we    = sel_ok;
                ctl.waddr = in_ch.thread_sel;
                ctl.wdata = in_ch.delay_ticks;
              end
              REQ_SUSPEND: sus_nxt = sus_r | sel_m;
              REQ_RESUME:  sus_nxt = sus_r & ~sel_m;
              REQ_DISABLE: dis_nxt = dis_r | sel_m;
              REQ_ENABLE:  dis_nxt = dis_r & ~sel_m;
              default: ;
            endcase
          end
        end
      end
      ST_RD: begin
        ctl.re    = 1'b1;
        ctl.raddr = THR_W'(idx_r);
        st_nxt    = ST_UPD;
      end
      ST_UPD: begin
        // Decrement a running counter; release the thread when it expires
        ctl.we    = sts.nz;
        ctl.waddr = THR_W'(idx_r);
        ctl.wdata = sts.dec;
        if (sts.expire) begin
          dis_nxt = dis_r & ~(MASK_W'(1) << idx_r);
        end
        if (idx_r == IDX_LAST) begin
          st_nxt = ST_FIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          st_nxt  = ST_RD;
        end
      end
      ST_FIN: begin
        load   = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ch.ready) || load;

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      idx_r       <= '0;
      dis_r       <= DIS_RST & ALL_M;
      sus_r       <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      dis_r       <= dis_nxt;
      sus_r       <= sus_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register: hold the item until it is taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_dis_r  <= dis_nxt & ALL_M;
      out_sus_r  <= sus_nxt & ALL_M;
      out_rdy_r  <= ~(dis_nxt | sus_nxt) & ALL_M;
      out_tick_r <= tick_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.disabled_mask  = out_dis_r;
  assign out_ch.suspended_mask = out_sus_r;
  assign out_ch.ready_mask     = out_rdy_r;
  assign out_ch.tick_total     = out_tick_r;

  // Checks
  `TDTB_ASSERT_NXT(a_tick_starts_scan, clk, rst_n, in_acc && is_tick, st_r == ST_RD, "tick did not start the counter scan")
  `TDTB_ASSERT_NXT(a_tick_count_step, clk, rst_n, in_acc && is_tick, tick_r == $past(tick_r) + TICK_W'(1), "tick count did not advance by one")
  `TDTB_ASSERT_IMP(a_no_result_in_scan, clk, rst_n, st_r == ST_RD || st_r == ST_UPD, !out_valid_r, "result pending during a tick scan")
  `TDTB_ASSERT_IMP(a_masks_disjoint, clk, rst_n, out_valid_r, (out_dis_r & out_rdy_r) == '0, "thread both disabled and ready")

endmodule
